@@ rtl/core/lcg_permutation_noise_positions_macros.svh @@
// ----------------------------------------------------------------------------
// lcg_permutation_noise_positions assertion macros
// Concurrent check macros on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LCG_PERMUTATION_NOISE_POSITIONS_MACROS_SVH
`define LCG_PERMUTATION_NOISE_POSITIONS_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LCGPN_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LCGPN_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LCGPN_ASSERT_IMP(label, ante, cons, msg)
`define LCGPN_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/core/lcgpn_pkg.sv @@
// ----------------------------------------------------------------------------
// lcgpn_pkg
// Shared types and constants of the LCG permutation noise-position block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgpn_pkg;

	// default table depth
	localparam int MAX_SIZE_DEFAULT = 1024;

	// field widths
	localparam int ARRAY_SIZE_W = 11;
	localparam int SEED_W       = 32;
	localparam int PASSES_W     = 8;
	localparam int RANK_W       = 10;
	localparam int LEVEL_W      = 16;
	localparam int POS_W        = 10;

	// generator
	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_ADD = 32'd12345;
	localparam int          RAND_LSB = 16;
	localparam int          RAND_W   = 15;

	// register reset values
	localparam logic [ARRAY_SIZE_W-1:0] ARRAY_SIZE_RST = 11'd1024;
	localparam logic [SEED_W-1:0]       SEED_RST       = 32'd2542;
	localparam logic [PASSES_W-1:0]     PASSES_RST     = 8'd20;

	// register indexes (byte address 4*index)
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_ARRAY_SIZE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SEED       = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PASSES     = 2'd2;

	// operation codes
	localparam logic OP_BUILD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_STEP,
		ST_MOD,
		ST_RDJ,
		ST_WRI,
		ST_WRJ,
		ST_BDONE,
		ST_QRY
	} state_t;

endpackage

`default_nettype wire

@@ rtl/core/lcgpn_ram.sv @@
// ----------------------------------------------------------------------------
// lcgpn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgpn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/lcg_permutation_noise_positions.sv @@
// ----------------------------------------------------------------------------
// lcg_permutation_noise_positions
// Permutation table built by an LCG-driven swap shuffle, queried per rank.
// ----------------------------------------------------------------------------
// A query: the accept cycle reads the table RAM, and the result strobe (done)
// follows in the next cycle. A build fills size entries, then runs passes *
// size swaps and ends with a result strobe; each swap is one LCG step, a
// bit-serial remainder (rand mod size) and two reads plus two writes on the
// table RAM. busy is high from accept until the result strobe.
// Results are shown for one cycle only and cannot be stalled by the receiver;
// a build gives one result with position 0, unmarked.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lcg_permutation_noise_positions_macros.svh"

module lcg_permutation_noise_positions
	import lcgpn_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// command
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               operation,
	input  wire logic [RANK_W-1:0]  rank,
	input  wire logic [LEVEL_W-1:0] noise_level,
	// result
	output logic                    done,
	output logic [POS_W-1:0]        position,
	output logic                    marked,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	localparam int AW  = $clog2(MAX_SIZE);
	localparam int SZW = $clog2(MAX_SIZE + 1);

	// configuration registers
	logic [ARRAY_SIZE_W-1:0] array_size_q;
	logic [SEED_W-1:0]       seed_value_q;
	logic [PASSES_W-1:0]     shuffle_passes_q;
	logic                    cfg_wr;
	logic [REG_IDX_W-1:0]    cfg_idx;

	// sequencer state
	state_t             state_q, state_d;
	logic [31:0]        rng_q;
	logic               built_q;
	logic [AW-1:0]      idx_q;
	logic [PASSES_W-1:0] pass_q;
	logic [3:0]         mod_cnt_q;
	logic               hit_q;
	logic               mark_q;
	logic [SZW-1:0]     rem_q;
	logic [AW-1:0]      ti_q;

	// derived
	logic [SZW-1:0]     size_w;
	logic [RAND_W-1:0]  lcg_out;
	logic [SZW:0]       rem_shift;
	logic [SZW-1:0]     rem_next;
	logic               idx_last;
	logic               pass_last;
	logic               mod_last;
	logic               accept;
	logic               q_hit;

	// RAM port
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [AW-1:0]      ram_rdata;

	// ------------------------------------------------------------------
	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			array_size_q     <= ARRAY_SIZE_RST;
			seed_value_q     <= SEED_RST;
			shuffle_passes_q <= PASSES_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ARRAY_SIZE: array_size_q     <= pwdata[ARRAY_SIZE_W-1:0];
				REG_SEED:       seed_value_q     <= pwdata[SEED_W-1:0];
				REG_PASSES:     shuffle_passes_q <= pwdata[PASSES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ARRAY_SIZE: prdata = 32'(array_size_q);
			REG_SEED:       prdata = seed_value_q;
			REG_PASSES:     prdata = 32'(shuffle_passes_q);
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// size in use: zero reads as one, clamped to the table depth
	always_comb begin
		if (array_size_q == '0) begin
			size_w = SZW'(1);
		end else if (32'(array_size_q) > 32'(MAX_SIZE)) begin
			size_w = SZW'(MAX_SIZE);
		end else begin
			size_w = SZW'(array_size_q);
		end
	end

	// ------------------------------------------------------------------
	// loop conditions and remainder step
	assign lcg_out   = rng_q[RAND_LSB +: RAND_W];
	assign idx_last  = (SZW'(idx_q) + SZW'(1)) == size_w;
	assign pass_last = (pass_q + PASSES_W'(1)) == shuffle_passes_q;
	assign mod_last  = mod_cnt_q == 4'(RAND_W - 1);
	assign accept    = start & ~busy;
	assign q_hit     = built_q && (32'(rank) < 32'(size_w));

	// one restoring step, dividend bits taken msb first
	always_comb begin
		rem_shift = {rem_q, lcg_out[4'(RAND_W - 1) - mod_cnt_q]};
		if (rem_shift >= {1'b0, size_w}) begin
			rem_next = SZW'(rem_shift - {1'b0, size_w});
		end else begin
			rem_next = SZW'(rem_shift);
		end
	end

	// ------------------------------------------------------------------
	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (operation == OP_BUILD) ? ST_FILL : ST_QRY;
				end
			end
			ST_FILL: begin
				if (idx_last) begin
					state_d = (shuffle_passes_q == '0) ? ST_BDONE : ST_STEP;
				end
			end
			ST_STEP: state_d = ST_MOD;
			ST_MOD: begin
				if (mod_last) begin
					state_d = ST_RDJ;
				end
			end
			ST_RDJ:  state_d = ST_WRI;
			ST_WRI:  state_d = ST_WRJ;
			ST_WRJ: begin
				state_d = (idx_last && pass_last) ? ST_BDONE : ST_STEP;
			end
			ST_BDONE: state_d = ST_IDLE;
			ST_QRY:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and RAM controls
	always_comb begin
		busy      = 1'b1;
		done      = 1'b0;
		position  = '0;
		marked    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = idx_q;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				ram_re    = start & (operation == OP_QUERY);
				ram_raddr = AW'(rank);
			end
			ST_FILL: begin
				ram_we = 1'b1;
			end
			ST_STEP: begin
				ram_re = 1'b1;
			end
			ST_MOD: ;
			ST_RDJ: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(rem_q);
			end
			ST_WRI: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			ST_WRJ: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(rem_q);
				ram_wdata = ti_q;
			end
			ST_BDONE: begin
				done = 1'b1;
			end
			ST_QRY: begin
				done     = 1'b1;
				position = hit_q ? POS_W'(ram_rdata) : '0;
				marked   = mark_q;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rng_q     <= '0;
			built_q   <= 1'b0;
			idx_q     <= '0;
			pass_q    <= '0;
			mod_cnt_q <= '0;
			hit_q     <= 1'b0;
			mark_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept && (operation == OP_BUILD)) begin
						rng_q  <= seed_value_q;
						idx_q  <= '0;
						pass_q <= '0;
					end
					if (accept && (operation == OP_QUERY)) begin
						hit_q  <= q_hit;
						mark_q <= q_hit && (LEVEL_W'(rank) < noise_level);
					end
				end
				ST_FILL: begin
					idx_q <= idx_last ? '0 : idx_q + AW'(1);
				end
				ST_STEP: begin
					rng_q     <= rng_q * LCG_MUL + LCG_ADD;
					mod_cnt_q <= '0;
				end
				ST_MOD: begin
					mod_cnt_q <= mod_cnt_q + 4'd1;
				end
				ST_WRJ: begin
					if (idx_last) begin
						idx_q  <= '0;
						pass_q <= pass_q + PASSES_W'(1);
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_BDONE: begin
					built_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// swap datapath: remainder and held entry i
	always_ff @(posedge clk) begin
		case (state_q)
			ST_STEP: rem_q <= '0;
			ST_MOD:  rem_q <= rem_next;
			ST_RDJ:  ti_q  <= ram_rdata;
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// permutation table
	lcgpn_ram #(
		.WIDTH (AW),
		.DEPTH (MAX_SIZE)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// checks
	`LCGPN_ASSERT_NXT(a_query_done, accept && (operation == OP_QUERY), done, "query without result")
	`LCGPN_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`LCGPN_ASSERT_IMP(a_rem_range, state_q == ST_MOD, rem_q < size_w, "remainder out of range")

endmodule

`default_nettype wire
